FILE: rtl/core/odo_pkg.sv
// odo_pkg: shared types, constants and tables for the wheel odometry block
// no dependencies; used by the cordic unit, the top level and the testbench
package odo_pkg;

  // cordic iteration count default
  localparam int unsigned CORDIC_STEPS_DEF = 24;

  // configuration port shape
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 36;

  // multiplier operand width
  localparam int unsigned MUL_W = 34;

  // register reset values
  localparam logic [23:0] STEP_LENGTH_RST    = 24'd558345;
  localparam logic [35:0] TURN_PER_METRE_RST = 36'd12897458030;

  // encoder wrap detection threshold
  localparam logic [16:0] WRAP_JUMP = 17'd30000;

  // cordic start value, gain compensation in q30
  localparam logic signed [MUL_W-1:0] CORDIC_X0 = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_STEP_LENGTH    = 3'd0,
    REG_TURN_PER_METRE = 3'd1,
    REG_START_X        = 3'd2,
    REG_START_Y        = 3'd3,
    REG_START_HEADING  = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DL0,
    ST_DL1,
    ST_DR0,
    ST_DR1,
    ST_DIFF,
    ST_TLO,
    ST_THI,
    ST_TSUM,
    ST_CINIT,
    ST_CORD,
    ST_MX,
    ST_MY,
    ST_FIN
  } odo_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  // atan(2^-i) in binary angle units
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // turn count update from previous and current raw counter
  function automatic logic [15:0] wrap_step(input logic [15:0] wraps,
                                            input logic [15:0] prev,
                                            input logic [15:0] now);
    logic signed [16:0] d;
    logic [16:0]        ad;
    logic               big;
    logic               prev_pos;
    logic               now_pos;
    d        = $signed({now[15], now}) - $signed({prev[15], prev});
    ad       = d[16] ? 17'(-d) : 17'(d);
    big      = ad > WRAP_JUMP;
    prev_pos = !prev[15] && (prev != 16'd0);
    now_pos  = !now[15] && (now != 16'd0);
    if (prev_pos && now[15] && big) begin
      return wraps + 16'd1;
    end else if (prev[15] && now_pos && big) begin
      return wraps - 16'd1;
    end else begin
      return wraps;
    end
  endfunction

endpackage

FILE: rtl/core/odo_if.sv
// odo_if: valid/ready channels for encoder samples and odometry results
// depends on nothing; payload widths follow the field definitions
interface odo_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_count;
  logic signed [15:0] right_count;

  modport source (output valid, output left_count, output right_count, input ready);
  modport sink   (input valid, input left_count, input right_count, output ready);
endinterface

interface odo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [31:0] heading;
  logic signed [31:0] step_travel;
  logic signed [31:0] step_turn;

  modport source (output valid, output pos_x, output pos_y, output heading,
                  output step_travel, output step_turn, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input heading,
                  input step_travel, input step_turn, output ready);
endinterface

FILE: rtl/core/odo_cordic.sv
// odo_cordic: iterative rotation-mode cordic, one micro-rotation per cycle
// depends on odo_pkg for the angle table and start constant
module odo_cordic #(
  parameter int unsigned STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [31:0]                         angle_i,
  output logic signed [odo_pkg::MUL_W-1:0]    cos_o,
  output logic signed [odo_pkg::MUL_W-1:0]    sin_o,
  output odo_pkg::cordic_stat_t               stat_o
);
  import odo_pkg::*;

  localparam int unsigned CW = $clog2(STEPS);

  logic [CW-1:0]           cnt_q;
  logic                    busy_q;
  logic                    done_q;
  logic signed [MUL_W-1:0] x_q, y_q, z_q;
  logic signed [MUL_W-1:0] xs, ys, at;
  logic signed [MUL_W-1:0] x_d, y_d, z_d;
  logic                    flip;
  logic [31:0]             ang_rot;

  // start: fold second and third quarter onto the first and fourth
  assign flip    = angle_i[31] ^ angle_i[30];
  assign ang_rot = angle_i + (flip ? 32'h8000_0000 : 32'h0);

  // one micro-rotation
  always_comb begin
    xs = x_q >>> cnt_q;
    ys = y_q >>> cnt_q;
    at = $signed({2'b00, atan_lut(5'(cnt_q))});
    if (!z_q[MUL_W-1]) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - at;
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + at;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // vector registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= CORDIC_X0;
      y_q <= '0;
      z_q <= $signed({{2{ang_rot[31]}}, ang_rot});
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign cos_o       = x_q;
  assign sin_o       = y_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("cordic started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("cordic done without run");
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> done_q) else $error("cordic stopped without done");

endmodule

FILE: rtl/core/encoder_unwrap_diff_drive_odometry.sv
// encoder_unwrap_diff_drive_odometry: wheel unwrap and differential-drive pose
// items are handled one at a time: a new sample is accepted only in idle, after
// the previous one has run through the shared 34x34 multiplier sequence and the
// iterative cordic; the next item is accepted while the previous result waits
// in the output register
// reset: turn counts, raw and unwrapped history and pose cleared, scales to defaults
module encoder_unwrap_diff_drive_odometry #(
  parameter int unsigned CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [odo_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [odo_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  odo_in_if.sink                           in_s,
  odo_out_if.source                        out_m
);
  import odo_pkg::*;

  odo_state_e state_q, state_d;

  // configuration and pose
  logic [23:0] sl_q;
  logic [35:0] tpm_q;
  logic [31:0] x_acc_q, y_acc_q, heading_q;
  // encoder history
  logic [15:0] lw_q, rw_q, lraw_q, rraw_q;
  logic [31:0] lfull_q, rfull_q;
  // per-item working registers
  logic [31:0]             fl_q, fr_q, dtmp_q, dl_q, turn_q;
  logic signed [32:0]      diff_q;
  logic signed [31:0]      travel_q;
  logic [63:0]             tacc_q;
  logic signed [MUL_W-1:0] trop_q;
  logic signed [2*MUL_W-1:0] prod_q;
  // output register
  logic                    out_valid_q;
  logic [31:0]             ox_q, oy_q, oh_q, otr_q, otu_q;

  logic                    in_acc, fin_go, in_ready, cor_start;
  logic signed [MUL_W-1:0] mul_a, mul_b, cos_w, sin_w;
  cordic_stat_t            cor_stat;
  logic [15:0]             lw_n, rw_n;
  logic [31:0]             dr_w, half_w, angle_w, y_new;
  logic signed [32:0]      sum_w;
  logic [63:0]             tsum_w;
  logic                    flip_w;

  function automatic logic [31:0] round_q30(input logic signed [2*MUL_W-1:0] p);
    logic [2*MUL_W-1:0] s;
    s = p + (2*MUL_W)'(64'd536870912);
    return s[61:30];
  endfunction

  assign in_acc = in_s.valid && in_ready;
  assign fin_go = (state_q == ST_FIN) && (!out_valid_q || out_m.ready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_DL0;
      ST_DL0:   state_d = ST_DL1;
      ST_DL1:   state_d = ST_DR0;
      ST_DR0:   state_d = ST_DR1;
      ST_DR1:   state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_TLO;
      ST_TLO:   state_d = ST_THI;
      ST_THI:   state_d = ST_TSUM;
      ST_TSUM:  state_d = ST_CINIT;
      ST_CINIT: state_d = ST_CORD;
      ST_CORD:  if (cor_stat.done) state_d = ST_MX;
      ST_MX:    state_d = ST_MY;
      ST_MY:    state_d = ST_FIN;
      ST_FIN:   if (fin_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // multiplier operands and handshake outputs
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    in_ready  = 1'b0;
    cor_start = 1'b0;
    case (state_q)
      ST_IDLE:  in_ready = 1'b1;
      ST_DL0:   begin
        mul_a = $signed({{2{fl_q[31]}}, fl_q});
        mul_b = $signed({10'b0, sl_q});
      end
      ST_DL1:   begin
        mul_a = $signed({{2{lfull_q[31]}}, lfull_q});
        mul_b = $signed({10'b0, sl_q});
      end
      ST_DR0:   begin
        mul_a = $signed({{2{fr_q[31]}}, fr_q});
        mul_b = $signed({10'b0, sl_q});
      end
      ST_DR1:   begin
        mul_a = $signed({{2{rfull_q[31]}}, rfull_q});
        mul_b = $signed({10'b0, sl_q});
      end
      ST_TLO:   begin
        mul_a = $signed({diff_q[32], diff_q});
        mul_b = $signed({16'b0, tpm_q[17:0]});
      end
      ST_THI:   begin
        mul_a = $signed({diff_q[32], diff_q});
        mul_b = $signed({16'b0, tpm_q[35:18]});
      end
      ST_CINIT: cor_start = 1'b1;
      ST_MX:    begin
        mul_a = trop_q;
        mul_b = cos_w;
      end
      ST_MY, ST_FIN: begin
        mul_a = trop_q;
        mul_b = sin_w;
      end
      default:  ;
    endcase
  end

  // wrap tracking on the incoming sample
  assign lw_n = wrap_step(lw_q, lraw_q, in_s.left_count);
  assign rw_n = wrap_step(rw_q, rraw_q, in_s.right_count);

  // working values
  assign dr_w    = dtmp_q - prod_q[43:12];
  assign sum_w   = $signed({dr_w[31], dr_w}) + $signed({dl_q[31], dl_q});
  assign tsum_w  = tacc_q + {prod_q[45:0], 18'b0};
  assign half_w  = {turn_q[31], turn_q[31:1]};
  assign angle_w = heading_q + half_w;
  assign flip_w  = angle_w[31] ^ angle_w[30];
  assign y_new   = y_acc_q + round_q30(prod_q);

  odo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (angle_w),
    .cos_o   (cos_w),
    .sin_o   (sin_w),
    .stat_o  (cor_stat)
  );

  // control state, history, pose and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      sl_q        <= STEP_LENGTH_RST;
      tpm_q       <= TURN_PER_METRE_RST;
      x_acc_q     <= '0;
      y_acc_q     <= '0;
      heading_q   <= '0;
      lw_q        <= '0;
      rw_q        <= '0;
      lraw_q      <= '0;
      rraw_q      <= '0;
      lfull_q     <= '0;
      rfull_q     <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_m.ready) out_valid_q <= 1'b0;
      if (in_acc) begin
        lw_q   <= lw_n;
        rw_q   <= rw_n;
        lraw_q <= in_s.left_count;
        rraw_q <= in_s.right_count;
      end
      if (state_q == ST_MY) x_acc_q <= x_acc_q + round_q30(prod_q);
      if (fin_go) begin
        y_acc_q     <= y_new;
        heading_q   <= heading_q + turn_q;
        lfull_q     <= fl_q;
        rfull_q     <= fr_q;
        out_valid_q <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_STEP_LENGTH:    sl_q  <= cfg_wdata_i[23:0];
          REG_TURN_PER_METRE: tpm_q <= cfg_wdata_i;
          REG_START_X:        x_acc_q   <= cfg_wdata_i[31:0];
          REG_START_Y:        y_acc_q   <= cfg_wdata_i[31:0];
          REG_START_HEADING:  heading_q <= cfg_wdata_i[31:0];
          default:            ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_acc) begin
      fl_q <= {lw_n, 16'b0} + {{16{in_s.left_count[15]}}, in_s.left_count};
      fr_q <= {rw_n, 16'b0} + {{16{in_s.right_count[15]}}, in_s.right_count};
    end
    case (state_q)
      ST_DL1:   dtmp_q <= prod_q[43:12];
      ST_DR0:   dl_q   <= dtmp_q - prod_q[43:12];
      ST_DR1:   dtmp_q <= prod_q[43:12];
      ST_DIFF:  begin
        diff_q   <= $signed({dr_w[31], dr_w}) - $signed({dl_q[31], dl_q});
        travel_q <= sum_w[32:1];
      end
      ST_THI:   tacc_q <= prod_q[63:0];
      ST_TSUM:  turn_q <= tsum_w[51:20];
      ST_CINIT: trop_q <= flip_w ? -$signed({{2{travel_q[31]}}, travel_q})
                                 :  $signed({{2{travel_q[31]}}, travel_q});
      default:  ;
    endcase
    if (fin_go) begin
      ox_q  <= x_acc_q;
      oy_q  <= y_new;
      oh_q  <= heading_q + turn_q;
      otr_q <= travel_q;
      otu_q <= turn_q;
    end
  end

  assign in_s.ready        = in_ready;
  assign out_m.valid       = out_valid_q;
  assign out_m.pos_x       = ox_q;
  assign out_m.pos_y       = oy_q;
  assign out_m.heading     = oh_q;
  assign out_m.step_travel = otr_q;
  assign out_m.step_turn   = otu_q;

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_s.ready) else $error("ready while busy");
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_DL0)) else $error("accept did not start sequence");
  a_cordic_only_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_stat.busy |-> (state_q == ST_CORD)) else $error("cordic runs outside wait");

endmodule

FILE: dv/encoder_unwrap_diff_drive_odometry_tb.sv
// testbench for encoder_unwrap_diff_drive_odometry: drives encoder samples and register
// settings, predicts unwrapped travel and pose per item and checks every result
// depends on odo_pkg, odo_in_if, odo_out_if and the block itself
`timescale 1ns / 1ps

module encoder_unwrap_diff_drive_odometry_tb;
  import odo_pkg::*;

  localparam int unsigned REG_SPAN   = 5;
  localparam int unsigned WATCH_MAX  = 3000;
  localparam int unsigned DRAIN_WAIT = CORDIC_STEPS_DEF + 30;
  localparam int unsigned PHASES     = 5;
  localparam int unsigned RAND_ITEMS = 160;
  localparam int unsigned HOLD_LEN   = 400;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  odo_in_if  in_ch ();
  odo_out_if out_ch ();

  encoder_unwrap_diff_drive_odometry dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_s       (in_ch.sink),
    .out_m      (out_ch.source)
  );

  typedef struct {
    bit [31:0] pos_x;
    bit [31:0] pos_y;
    bit [31:0] heading;
    bit [31:0] step_travel;
    bit [31:0] step_turn;
  } pose_t;

  // pose predictor and store of expected poses
  class odo_scoreboard;
    bit [23:0] step_len;
    bit [35:0] turn_scale;
    bit [15:0] wraps_l, wraps_r, raw_l, raw_r;
    bit [31:0] full_l, full_r;
    bit [31:0] x_acc, y_acc, hd_acc;
    pose_t     pose_q[$];
    int        errors;
    bit [31:0] atan_rom[24];

    function new();
      step_len   = STEP_LENGTH_RST;
      turn_scale = TURN_PER_METRE_RST;
      atan_rom = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                   32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                   32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                   32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                   32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                   32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    endfunction

    function void write_reg(int unsigned idx, bit [35:0] v);
      case (idx)
        REG_STEP_LENGTH:    step_len = v[23:0];
        REG_TURN_PER_METRE: turn_scale = v;
        REG_START_X:        x_acc = v[31:0];
        REG_START_Y:        y_acc = v[31:0];
        REG_START_HEADING:  hd_acc = v[31:0];
        default: ;
      endcase
    endfunction

    function bit [15:0] next_turns(bit [15:0] w, int prev, int now);
      int d;
      d = now - prev;
      if (d < 0) d = -d;
      if (prev > 0 && now < 0 && d > int'(WRAP_JUMP)) w = w + 16'd1;
      else if (prev < 0 && now > 0 && d > int'(WRAP_JUMP)) w = w - 16'd1;
      return w;
    endfunction

    function longint wheel_dist(bit [31:0] full);
      longint p;
      p = longint'($signed(full)) * longint'(step_len);
      return p >>> 12;
    endfunction

    // wrapped 32-bit travel between two unwrapped counts
    function longint wheel_travel(bit [31:0] now_full, bit [31:0] prev_full);
      longint d;
      d = wheel_dist(now_full) - wheel_dist(prev_full);
      return longint'($signed(d[31:0]));
    endfunction

    // rotation-mode cordic with half-turn fold, q30 results
    function void sin_cos(bit [31:0] ang, output longint c, output longint s);
      bit     fold;
      longint x, y, z, nx;
      fold = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
      if (fold) ang = ang + 32'h80000000;
      z = longint'($signed(ang));
      x = CORDIC_X0;
      y = 0;
      for (int i = 0; i < 24; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z  = z - longint'(atan_rom[i]);
        end else begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z  = z + longint'(atan_rom[i]);
        end
        x = nx;
      end
      c = fold ? -x : x;
      s = fold ? -y : y;
    endfunction

    function void note_input(bit [15:0] l, bit [15:0] r);
      bit [31:0] fl, fr, turn, half;
      bit [63:0] prod;
      longint    dl, dr, trv, c, s, mx, my;
      pose_t     p;
      wraps_l = next_turns(wraps_l, int'($signed(raw_l)), int'($signed(l)));
      wraps_r = next_turns(wraps_r, int'($signed(raw_r)), int'($signed(r)));
      fl = {wraps_l, 16'd0} + {{16{l[15]}}, l};
      fr = {wraps_r, 16'd0} + {{16{r[15]}}, r};
      dl = wheel_travel(fl, full_l);
      dr = wheel_travel(fr, full_r);
      trv  = (dl + dr) >>> 1;
      prod = 64'(dr - dl) * 64'(turn_scale);
      turn = prod[51:20];
      half = {turn[31], turn[31:1]};
      sin_cos(hd_acc + half, c, s);
      mx = (trv * c + (64'sd1 <<< 29)) >>> 30;
      my = (trv * s + (64'sd1 <<< 29)) >>> 30;
      x_acc  = x_acc + mx[31:0];
      y_acc  = y_acc + my[31:0];
      hd_acc = hd_acc + turn;
      raw_l = l;
      raw_r = r;
      full_l = fl;
      full_r = fr;
      p.pos_x = x_acc;
      p.pos_y = y_acc;
      p.heading = hd_acc;
      p.step_travel = trv[31:0];
      p.step_turn = turn;
      pose_q.push_back(p);
    endfunction

    function void check(pose_t got);
      pose_t e;
      if (pose_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h", $time, got.pos_x, got.pos_y);
        errors++;
        return;
      end
      e = pose_q.pop_front();
      if (got.pos_x != e.pos_x) begin
        $display("%0t: pos_x exp %h got %h", $time, e.pos_x, got.pos_x);
        errors++;
      end
      if (got.pos_y != e.pos_y) begin
        $display("%0t: pos_y exp %h got %h", $time, e.pos_y, got.pos_y);
        errors++;
      end
      if (got.heading != e.heading) begin
        $display("%0t: heading exp %h got %h", $time, e.heading, got.heading);
        errors++;
      end
      if (got.step_travel != e.step_travel) begin
        $display("%0t: step_travel exp %h got %h", $time, e.step_travel, got.step_travel);
        errors++;
      end
      if (got.step_turn != e.step_turn) begin
        $display("%0t: step_turn exp %h got %h", $time, e.step_turn, got.step_turn);
        errors++;
      end
    endfunction
  endclass

  odo_scoreboard sb;
  int unsigned   idle_cycles;
  int unsigned   results_seen;
  bit [15:0]     walk_l, walk_r;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 40);
    return $urandom_range(41, 150);
  endfunction

  // offer one item and hold it until accepted
  task automatic send_item(bit [15:0] l, bit [15:0] r, bit quiet);
    int unsigned gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.left_count  <= l;
    in_ch.right_count <= r;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic write_cfg(int unsigned idx, bit [35:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx[CFG_IDX_W-1:0];
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.write_reg(idx, v);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // register settings per phase, extremes included
  task automatic apply_setting(int unsigned ph);
    case (ph)
      1: begin
        write_cfg(REG_STEP_LENGTH, 36'hFFFFFF);
        write_cfg(REG_TURN_PER_METRE, 36'hFFFFFFFFF);
        write_cfg(REG_START_X, 36'h07FFFFFFF);
        write_cfg(REG_START_Y, 36'h080000000);
        write_cfg(REG_START_HEADING, 36'hFFFFFFFF);
      end
      2: begin
        write_cfg(REG_STEP_LENGTH, 36'd0);
        write_cfg(REG_TURN_PER_METRE, 36'd0);
        write_cfg(REG_START_X, 36'h080000000);
        write_cfg(REG_START_Y, 36'h07FFFFFFF);
        write_cfg(REG_START_HEADING, 36'd0);
      end
      3: begin
        write_cfg(REG_STEP_LENGTH, 36'($urandom()));
        write_cfg(REG_TURN_PER_METRE, {4'($urandom()), 32'($urandom())});
        write_cfg(REG_START_X, 36'($urandom()));
        write_cfg(REG_START_Y, 36'($urandom()));
        write_cfg(REG_START_HEADING, 36'($urandom()));
      end
      default: begin
        write_cfg(REG_STEP_LENGTH, STEP_LENGTH_RST);
        write_cfg(REG_TURN_PER_METRE, TURN_PER_METRE_RST);
        write_cfg(REG_START_HEADING, 36'($urandom()));
      end
    endcase
    // indexes past the register list must be ignored
    for (int unsigned k = REG_SPAN; k < (1 << CFG_IDX_W); k++) begin
      write_cfg(k, {4'($urandom()), 32'($urandom())});
    end
  endtask

  // wheel counter walk with random steps that cross the 16-bit wrap
  task automatic random_items(int unsigned n);
    bit    quiet;
    int    dl, dr;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 9) == 0) begin
          dl = int'($urandom_range(0, 60000)) - 30000;
          dr = int'($urandom_range(0, 60000)) - 30000;
        end else begin
          dl = int'($urandom_range(0, 4000)) - 2000;
          dr = dl + int'($urandom_range(0, 400)) - 200;
        end
        walk_l = walk_l + 16'(dl);
        walk_r = walk_r + 16'(dr);
      end else begin
        walk_l = 16'($urandom());
        walk_r = 16'($urandom());
      end
      send_item(walk_l, walk_r, quiet);
    end
  endtask

  // accepted samples feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      sb.note_input(in_ch.left_count, in_ch.right_count);
    end
  end

  // accepted results are checked
  always @(posedge clk_i) begin
    pose_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.pos_x = out_ch.pos_x;
      got.pos_y = out_ch.pos_y;
      got.heading = out_ch.heading;
      got.step_travel = out_ch.step_travel;
      got.step_turn = out_ch.step_turn;
      sb.check(got);
      results_seen++;
    end
  end

  // watchdog on cycles without any item moving
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_MAX) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result receiver with random stalls and one long hold-off
  initial begin
    bit held;
    int unsigned n_on;
    int unsigned gap;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && results_seen >= 60) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      n_on = $urandom_range(1, 80);
      repeat (n_on) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // main sequence
  initial begin
    shortint dir_l[16];
    shortint dir_r[16];
    dir_l = '{0, 32767, -32768, 1, -30000, 0, 32767, 0, -32768, 0,
              15000, -15000, 15001, -14999, -1, 32767};
    dir_r = '{0, -32768, 32767, -1, 30000, 0, 32767, 0, -32768, 0,
              -15000, 15000, -14999, 15001, 1, -32768};
    sb = new();
    idle_cycles  = 0;
    results_seen = 0;
    walk_l = '0;
    walk_r = '0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_wdata_i <= '0;
    in_ch.valid <= 1'b0;
    in_ch.left_count <= '0;
    in_ch.right_count <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) apply_setting(ph);
      if (ph == 0) begin
        for (int k = 0; k < 16; k++) send_item(dir_l[k], dir_r[k], 1'b0);
      end
      random_items(RAND_ITEMS);
      in_ch.valid <= 1'b0;
      while (sb.pose_q.size() > 0) @(posedge clk_i);
      repeat (DRAIN_WAIT) @(posedge clk_i);
    end

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
